// ===== rtl/positional_insert_delete_array_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positional insert/delete array
// Shared property forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_TOP_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_TOP_MACROS_SVH

// same-cycle implication
`define PIDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pida_pkg.sv =====
// ----------------------------------------------------------------------------
// pida_pkg
// Types, codes and sizes shared by the positional insert/delete array.
// ----------------------------------------------------------------------------
`default_nettype none

package pida_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_INS  = 2'd0,
    ACT_DEL  = 2'd1,
    ACT_LIST = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_LISTED   = 3'd2,
    ST_INS_REJ  = 3'd3,
    ST_DEL_REJ  = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_LIST
  } fsm_t;

  typedef struct packed {
    action_t                   action;
    logic [CNT_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  element;
    logic [CNT_W-1:0]          slot;
    logic [CNT_W-1:0]          fill;
    logic                      last;
  } out_item_t;

  // command broadcast to every cell; idx is the insert/delete slot or the
  // wrap slot of a rotate
  typedef struct packed {
    cell_op_t                  op;
    logic [IDX_W-1:0]          idx;
    logic signed [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/pida_cell.sv =====
// ----------------------------------------------------------------------------
// pida_cell
// One slot of the array: holds an entry, or takes its left neighbor, its
// right neighbor, the head entry or the inserted value.
// ----------------------------------------------------------------------------
`default_nettype none

module pida_cell (
  input  wire logic                             clk,
  input  wire pida_pkg::cell_cmd_t              cmd,
  input  wire logic [pida_pkg::IDX_W-1:0]       my_index,
  input  wire logic signed [pida_pkg::DATA_W-1:0] left,
  input  wire logic signed [pida_pkg::DATA_W-1:0] right,
  input  wire logic signed [pida_pkg::DATA_W-1:0] head,
  output logic signed [pida_pkg::DATA_W-1:0]      q
);

  logic signed [pida_pkg::DATA_W-1:0] q_next;

  always_comb begin
    unique case (cmd.op)
      pida_pkg::CELL_INS: begin
        if (my_index == cmd.idx) q_next = cmd.value;
        else if (my_index > cmd.idx) q_next = left;
        else q_next = q;
      end
      pida_pkg::CELL_DEL: begin
        q_next = (my_index >= cmd.idx) ? right : q;
      end
      pida_pkg::CELL_ROT: begin
        if (my_index == cmd.idx) q_next = head;
        else if (my_index < cmd.idx) q_next = right;
        else q_next = q;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

// ===== rtl/positional_insert_delete_array_top.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_array_top
// Packed array of signed entries in a row of shifting cells, with insert,
// delete and in-order listing.
// ----------------------------------------------------------------------------
//  channel | signals                      | item
//  --------+------------------------------+--------------------------------
//  in      | in_valid, in_stall, in_item  | action, position, value
//  out     | out_valid, out_stall, out_item | status, element, slot, fill, last
//
//  Insert and delete shift all cells in parallel. After a list is accepted,
//  the cells rotate the stored entries through cell 0, which feeds the
//  output, and end in their order. An output stall pauses the rotation.
//  Input is stalled during a list and while the output register is held.
//  Reset clears the count; entry contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_array_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pida_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pida_pkg::out_item_t       out_item
);

  `include "positional_insert_delete_array_top_macros.svh"

  localparam int N = pida_pkg::DEPTH;

  pida_pkg::fsm_t                      state, state_next;
  logic [pida_pkg::CNT_W-1:0]          occ, occ_next;
  logic [pida_pkg::CNT_W-1:0]          list_cnt;
  logic signed [pida_pkg::DATA_W-1:0]  cell_q [N];
  pida_pkg::cell_cmd_t                 cmd;
  pida_pkg::out_item_t                 out_next;
  logic                                out_free, in_fire, out_load, list_step;
  logic                                ins_ok, del_ok, list_last;
  logic [pida_pkg::CNT_W-1:0]          pos_m1, occ_m1;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != pida_pkg::FSM_IDLE) || !out_free;
  assign in_fire   = in_valid && !in_stall;

  assign pos_m1    = in_item.position - pida_pkg::CNT_W'(1);
  assign occ_m1    = occ - pida_pkg::CNT_W'(1);
  assign ins_ok    = (in_item.position != '0) &&
                     (in_item.position <= occ + pida_pkg::CNT_W'(1)) &&
                     (occ != pida_pkg::CNT_W'(N));
  assign del_ok    = (in_item.position != '0) && (in_item.position <= occ);
  assign list_last = (list_cnt + pida_pkg::CNT_W'(1)) == occ;

  // cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [pida_pkg::DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_l0
      assign left_d = '0;
    end else begin : g_ln
      assign left_d = cell_q[i-1];
    end
    if (i == N - 1) begin : g_rN
      assign right_d = '0;
    end else begin : g_rn
      assign right_d = cell_q[i+1];
    end
    pida_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .my_index (pida_pkg::IDX_W'(i)),
      .left     (left_d),
      .right    (right_d),
      .head     (cell_q[0]),
      .q        (cell_q[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pida_pkg::FSM_IDLE: begin
        if (in_fire && in_item.action == pida_pkg::ACT_LIST && occ != '0)
          state_next = pida_pkg::FSM_LIST;
      end
      pida_pkg::FSM_LIST: begin
        if (out_free && list_last) state_next = pida_pkg::FSM_IDLE;
      end
      default: state_next = pida_pkg::FSM_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cmd.op    = pida_pkg::CELL_HOLD;
    cmd.idx   = pos_m1[pida_pkg::IDX_W-1:0];
    cmd.value = in_item.value;
    out_load  = 1'b0;
    list_step = 1'b0;
    occ_next  = occ;
    out_next  = '0;
    out_next.last = 1'b1;
    unique case (state)
      pida_pkg::FSM_IDLE: begin
        if (in_fire) begin
          unique case (in_item.action)
            pida_pkg::ACT_INS: begin
              out_load = 1'b1;
              if (ins_ok) begin
                cmd.op          = pida_pkg::CELL_INS;
                occ_next        = occ + pida_pkg::CNT_W'(1);
                out_next.status = pida_pkg::ST_INSERTED;
              end else begin
                out_next.status = pida_pkg::ST_INS_REJ;
              end
            end
            pida_pkg::ACT_DEL: begin
              out_load = 1'b1;
              if (del_ok) begin
                cmd.op          = pida_pkg::CELL_DEL;
                occ_next        = occ_m1;
                out_next.status = pida_pkg::ST_DELETED;
              end else begin
                out_next.status = pida_pkg::ST_DEL_REJ;
              end
            end
            pida_pkg::ACT_LIST: begin
              if (occ == '0) begin
                out_load        = 1'b1;
                out_next.status = pida_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      pida_pkg::FSM_LIST: begin
        if (out_free) begin
          out_load         = 1'b1;
          list_step        = 1'b1;
          cmd.op           = pida_pkg::CELL_ROT;
          cmd.idx          = occ_m1[pida_pkg::IDX_W-1:0];
          out_next.status  = pida_pkg::ST_LISTED;
          out_next.element = cell_q[0];
          out_next.slot    = list_cnt + pida_pkg::CNT_W'(1);
          out_next.last    = list_last;
        end
      end
      default: ;
    endcase
    out_next.fill = occ_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pida_pkg::FSM_IDLE;
      occ       <= '0;
      list_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (state == pida_pkg::FSM_IDLE) list_cnt <= '0;
      else if (list_step) list_cnt <= list_cnt + pida_pkg::CNT_W'(1);
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_item <= out_next;
  end

  `PIDA_ASSERT_NOW(a_occ_range, 1'b1, occ <= pida_pkg::CNT_W'(N), "count above depth")
  `PIDA_ASSERT_NOW(a_list_cnt, state == pida_pkg::FSM_LIST, occ != '0 && list_cnt < occ, "list count out of range")
  `PIDA_ASSERT_NEXT(a_list_end, state == pida_pkg::FSM_LIST && out_free && list_last, state == pida_pkg::FSM_IDLE, "list did not end")
  `PIDA_ASSERT_NEXT(a_occ_hold, !in_fire, $stable(occ), "count changed without an item")

endmodule

`default_nettype wire
